// ===== rtl/tfds_pkg.sv =====
// tfds_pkg: shared widths and controller/datapath handshake structs for the
// transmit frame descriptor segmenter. No dependencies.
`timescale 1ns / 1ps

package tfds_pkg;

  // frame length and buffer size fields
  localparam int unsigned LEN_W = 13;
  // descriptor index as carried in a result word
  localparam int unsigned DESC_W = 2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture an input word
    logic emit_busy;  // write the busy-error result
    logic emit_seg;   // write one segment result and step the ring
  } seg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;   // result register can take a word this cycle
    logic seg_last;   // remaining length fits in one buffer
  } seg_sts_t;

endpackage

// ===== rtl/tfds_if.sv =====
// tfds_in_if / tfds_out_if: valid/ready channels of the segmenter.
// Depends on tfds_pkg for field widths.
`timescale 1ns / 1ps

interface tfds_in_if;
  logic                           valid;
  logic                           ready;
  logic [tfds_pkg::LEN_W-1:0]     frame_length;
  logic                           head_owned;
  logic                           tx_buffer_unavailable;

  modport source (output valid, output frame_length, output head_owned,
                  output tx_buffer_unavailable, input ready);
  modport sink (input valid, input frame_length, input head_owned,
                input tx_buffer_unavailable, output ready);
endinterface

interface tfds_out_if;
  logic                           valid;
  logic                           ready;
  logic [tfds_pkg::DESC_W-1:0]    desc_index;
  logic                           first_segment;
  logic                           last_segment;
  logic [tfds_pkg::LEN_W-1:0]     buffer_size;
  logic                           busy_error;
  logic                           resume_poll;
  logic                           end_of_run;

  modport source (output valid, output desc_index, output first_segment,
                  output last_segment, output buffer_size, output busy_error,
                  output resume_poll, output end_of_run, input ready);
  modport sink (input valid, input desc_index, input first_segment,
                input last_segment, input buffer_size, input busy_error,
                input resume_poll, input end_of_run, output ready);
endinterface

// ===== rtl/tfds_ctrl.sv =====
// tfds_ctrl: controller state machine of the segmenter; accepts input words
// and sequences one segment per cycle while the result register can take a word. Depends on tfds_pkg.
`timescale 1ns / 1ps

module tfds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                head_owned_i,
  output logic                in_ready_o,
  input  tfds_pkg::seg_sts_t  sts_i,
  output tfds_pkg::seg_cmd_t  cmd_o
);
  import tfds_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (head_owned_i) begin
            cmd_o.emit_busy = 1'b1;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_seg = 1'b1;
          if (sts_i.seg_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/tfds_datapath.sv =====
// tfds_datapath: remaining-length register, ring index and result register
// of the segmenter. Depends on tfds_pkg and tfds_if.
`timescale 1ns / 1ps

module tfds_datapath #(
  parameter int unsigned BUF_SIZE   = 1536,
  parameter int unsigned RING_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tfds_pkg::LEN_W-1:0]    frame_length_i,
  input  logic                          tx_buffer_unavailable_i,
  input  tfds_pkg::seg_cmd_t            cmd_i,
  output tfds_pkg::seg_sts_t            sts_o,
  tfds_out_if.source                    out_o
);
  import tfds_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam logic [LEN_W-1:0] BufLen  = LEN_W'(BUF_SIZE);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(RING_DEPTH - 1);

  logic [LEN_W-1:0]  rem_q, rem_d;
  logic              unavail_q;
  logic              first_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W+1:0]  idx_ext;
  logic              seg_last;

  logic              valid_q;
  logic [DESC_W-1:0] desc_index_q;
  logic              first_segment_q;
  logic              last_segment_q;
  logic [LEN_W-1:0]  buffer_size_q;
  logic              busy_error_q;
  logic              resume_poll_q;
  logic              end_of_run_q;

  // segment decision and ring step
  assign seg_last      = (rem_q <= BufLen);
  assign rem_d         = rem_q - BufLen;
  assign idx_d         = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign idx_ext       = {2'b00, idx_q};
  assign sts_o.seg_last = seg_last;
  assign sts_o.out_free = !valid_q || out_o.ready;

  // frame registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q     <= frame_length_i;
      unavail_q <= tx_buffer_unavailable_i;
      first_q   <= 1'b1;
    end else if (cmd_i.emit_seg) begin
      rem_q   <= rem_d;
      first_q <= 1'b0;
    end
  end

  // ring index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.emit_seg) begin
      idx_q <= idx_d;
    end
  end

  // result word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit_busy || cmd_i.emit_seg) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_busy) begin
      desc_index_q    <= '0;
      first_segment_q <= 1'b0;
      last_segment_q  <= 1'b0;
      buffer_size_q   <= '0;
      busy_error_q    <= 1'b1;
      resume_poll_q   <= 1'b0;
      end_of_run_q    <= 1'b1;
    end else if (cmd_i.emit_seg) begin
      desc_index_q    <= idx_ext[DESC_W-1:0];
      first_segment_q <= first_q;
      last_segment_q  <= seg_last;
      buffer_size_q   <= seg_last ? rem_q : BufLen;
      busy_error_q    <= 1'b0;
      resume_poll_q   <= seg_last && unavail_q;
      end_of_run_q    <= seg_last;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.desc_index    = desc_index_q;
  assign out_o.first_segment = first_segment_q;
  assign out_o.last_segment  = last_segment_q;
  assign out_o.buffer_size   = buffer_size_q;
  assign out_o.busy_error    = busy_error_q;
  assign out_o.resume_poll   = resume_poll_q;
  assign out_o.end_of_run    = end_of_run_q;

endmodule

// ===== rtl/tx_frame_descriptor_segmenter_top.sv =====
// tx_frame_descriptor_segmenter_top: top level of the transmit descriptor
// segmenter. Depends on tfds_pkg, tfds_if, tfds_ctrl and tfds_datapath.
`timescale 1ns / 1ps

// Places one transmit frame per input word onto a ring of RING_DEPTH
// descriptors, one result word per segment of up to BUF_SIZE bytes, the
// last carrying the remainder; a frame whose head descriptor is still owned
// gets a single busy-error word and leaves the ring index alone. The
// controller first loads the word, then the datapath's single length
// subtractor produces one segment per cycle into the result register,
// while a busy word is written into the result register at acceptance.
// Each segment waits while the result register holds an unaccepted word.
// The next frame is accepted once the last word of the previous one leaves
// the result register, at the earliest in the cycle after that word is
// written. The ring index resets to zero.
module tx_frame_descriptor_segmenter_top #(
  parameter int unsigned BUF_SIZE   = 1536,
  parameter int unsigned RING_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfds_in_if.sink     in_i,
  tfds_out_if.source  out_o
);
  import tfds_pkg::*;

  seg_cmd_t cmd;
  seg_sts_t sts;

  // controller
  tfds_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .head_owned_i (in_i.head_owned),
    .in_ready_o   (in_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // datapath
  tfds_datapath #(
    .BUF_SIZE   (BUF_SIZE),
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .frame_length_i          (in_i.frame_length),
    .tx_buffer_unavailable_i (in_i.tx_buffer_unavailable),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .out_o                   (out_o)
  );

endmodule

// ===== verif/tb_tx_frame_descriptor_segmenter_top.sv =====
// tb_tx_frame_descriptor_segmenter_top: self-checking bench for the transmit
// descriptor segmenter, with random idles on both channels and a ring model.
// Depends on tfds_pkg, tfds_if and tx_frame_descriptor_segmenter_top.
`timescale 1ns / 1ps

module tb_tx_frame_descriptor_segmenter_top;

  import tfds_pkg::*;

  localparam int unsigned BUF_SIZE   = 1536;
  localparam int unsigned RING_DEPTH = 4;
  localparam int unsigned MAX_LEN    = (1 << LEN_W) - 1;
  localparam int unsigned NUM_RANDOM = 445;
  localparam int unsigned DRAIN_CYC  = 20;

  // one frame request as offered on the input channel
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             owned;
    logic             unavail;
  } frame_t;

  // one descriptor word as seen on the output channel
  typedef struct packed {
    logic [DESC_W-1:0] index;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  size;
    logic              busy;
    logic              resume;
    logic              eor;
  } desc_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tfds_in_if  in_ch ();
  tfds_out_if out_ch ();

  tx_frame_descriptor_segmenter_top #(
    .BUF_SIZE   (BUF_SIZE),
    .RING_DEPTH (RING_DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  frame_t      frame_q[$];
  desc_word_t  expected_desc_q[$];
  int unsigned ring_head;
  int unsigned err_cnt;

  frame_t      drv_cur;
  bit          drv_busy;
  int unsigned drv_gap;
  bit          in_burst;
  int unsigned out_stall;
  bit          out_burst;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // idle length: mostly short, a few long, none during a burst stretch
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void add_frame(input int unsigned len, input bit owned,
                                    input bit unavail);
    frame_t f;
    f.len     = len[LEN_W-1:0];
    f.owned   = owned;
    f.unavail = unavail;
    frame_q.push_back(f);
  endfunction

  // expected descriptor words for one accepted frame, steps the ring head
  function automatic void segment_frame(input frame_t f);
    desc_word_t  w;
    int unsigned nseg;
    int unsigned k;
    if (f.owned) begin
      w      = '0;
      w.busy = 1'b1;
      w.eor  = 1'b1;
      expected_desc_q.push_back(w);
      return;
    end
    nseg = (f.len > BUF_SIZE) ? (int'(f.len) + BUF_SIZE - 1) / BUF_SIZE : 1;
    for (k = 0; k < nseg; k++) begin
      w        = '0;
      w.index  = ring_head[DESC_W-1:0];
      w.first  = (k == 0);
      w.last   = (k + 1 == nseg);
      w.size   = w.last ? LEN_W'(int'(f.len) - (nseg - 1) * BUF_SIZE)
                        : LEN_W'(BUF_SIZE);
      w.resume = w.last && f.unavail;
      w.eor    = w.last;
      expected_desc_q.push_back(w);
      ring_head = (ring_head + 1 >= RING_DEPTH) ? 0 : ring_head + 1;
    end
  endfunction

  task automatic check_word(input desc_word_t got, input desc_word_t want);
    if (got.index !== want.index)
      report($sformatf("desc_index %0d, expected %0d", got.index, want.index));
    if (got.first !== want.first)
      report($sformatf("first_segment %0b, expected %0b", got.first, want.first));
    if (got.last !== want.last)
      report($sformatf("last_segment %0b, expected %0b", got.last, want.last));
    if (got.size !== want.size)
      report($sformatf("buffer_size %0d, expected %0d", got.size, want.size));
    if (got.busy !== want.busy)
      report($sformatf("busy_error %0b, expected %0b", got.busy, want.busy));
    if (got.resume !== want.resume)
      report($sformatf("resume_poll %0b, expected %0b", got.resume, want.resume));
    if (got.eor !== want.eor)
      report($sformatf("end_of_run %0b, expected %0b", got.eor, want.eor));
  endtask

  // input driver: offers queued frames, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid                 <= 1'b0;
      in_ch.frame_length          <= '0;
      in_ch.head_owned            <= 1'b0;
      in_ch.tx_buffer_unavailable <= 1'b0;
      drv_busy = 1'b0;
      drv_gap  = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        segment_frame(drv_cur);
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (frame_q.size() != 0) begin
          drv_cur  = frame_q.pop_front();
          drv_busy = 1'b1;
          drv_gap  = pick_gap(in_burst);
          if ($urandom_range(39) == 0) in_burst = !in_burst;
          in_ch.frame_length          <= drv_cur.len;
          in_ch.head_owned            <= drv_cur.owned;
          in_ch.tx_buffer_unavailable <= drv_cur.unavail;
        end
      end
      in_ch.valid <= drv_busy;
    end
  end

  // output monitor: random back-pressure, checks each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    desc_word_t got;
    bit         rdy;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.index  = out_ch.desc_index;
        got.first  = out_ch.first_segment;
        got.last   = out_ch.last_segment;
        got.size   = out_ch.buffer_size;
        got.busy   = out_ch.busy_error;
        got.resume = out_ch.resume_poll;
        got.eor    = out_ch.end_of_run;
        if (expected_desc_q.size() == 0)
          report($sformatf("unexpected word %h", got));
        else
          check_word(got, expected_desc_q.pop_front());
      end
      rdy = (out_stall == 0);
      if (out_stall > 0) begin
        out_stall--;
      end else begin
        out_stall = pick_gap(out_burst);
        if ($urandom_range(59) == 0) out_burst = !out_burst;
      end
      out_ch.ready <= rdy;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned r;
    int unsigned len;
    rst_ni                      = 1'b0;
    in_ch.valid                 = 1'b0;
    in_ch.frame_length          = '0;
    in_ch.head_owned            = 1'b0;
    in_ch.tx_buffer_unavailable = 1'b0;
    out_ch.ready                = 1'b0;
    ring_head = 0;
    err_cnt   = 0;
    in_burst  = 1'b0;
    out_burst = 1'b0;

    // directed: empty, short, buffer boundaries, max length, busy head
    add_frame(0, 0, 0);
    add_frame(1, 0, 1);
    add_frame(BUF_SIZE - 1, 0, 0);
    add_frame(BUF_SIZE, 0, 1);
    add_frame(BUF_SIZE + 1, 0, 0);
    add_frame(2 * BUF_SIZE, 0, 0);
    add_frame(2 * BUF_SIZE + 1, 0, 1);
    add_frame(MAX_LEN, 0, 1);
    add_frame(5 * BUF_SIZE, 0, 0);
    add_frame(5 * BUF_SIZE + 1, 0, 0);
    add_frame(MAX_LEN, 1, 1);
    add_frame(0, 1, 0);
    add_frame(3 * BUF_SIZE, 0, 1);
    add_frame(4 * BUF_SIZE, 0, 0);
    add_frame(4096, 0, 0);
    add_frame(2730, 1, 0);
    add_frame(5461, 0, 1);

    // random: short frames, near-multiple lengths and the full range
    repeat (NUM_RANDOM) begin
      r = $urandom_range(99);
      if (r < 40)      len = $urandom_range(BUF_SIZE);
      else if (r < 55) len = $urandom_range(5, 1) * BUF_SIZE + $urandom_range(2) - 1;
      else             len = $urandom_range(MAX_LEN);
      add_frame(len, $urandom_range(99) < 15, $urandom_range(1));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (frame_q.size() != 0 || drv_busy) @(negedge clk_i);
    while (expected_desc_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (expected_desc_q.size() != 0)
      report($sformatf("%0d expected words never arrived", expected_desc_q.size()));

    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
